/* src/mp2d_pkg.sv */
// Shared types and constants of the streaming 2-D max pooling block.
// Used by mp2d_ctrl and max_pool_2d_stream_top; depends on nothing.
package mp2d_pkg;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int POOL_REG_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_INPUT_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_ROWS  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_COLS  = 2'd3;

	// Row count bound of the feature map.
	localparam int ROW_MAX = 1024;
	localparam int ROW_W   = 11;
	localparam int ROWS_RST = 64;
	localparam int COLS_RST = 64;
	localparam int POOL_RST = 2;

	// Where the current sample sits relative to its pooling window.
	typedef struct packed {
		logic in_win;      // sample belongs to a complete window
		logic first_col;   // first column of a window row
		logic last_col;    // last column of a window row
		logic use_partial; // window rows above this one hold a partial maximum
		logic last_row;    // bottom row of the window
		logic frame_last;  // bottom-right sample of the frame's last window
	} pos_flags_t;

endpackage

/* src/mp2d_store.sv */
// Partial-maximum store, one entry per pooled column.
// One write port, one registered read port with write-through forwarding. No package use.
module mp2d_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// A read that meets a write to the same entry returns the new value.
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && waddr == raddr) begin
				rdata <= wdata;
			end else begin
				rdata <= mem[raddr];
			end
		end
	end

endmodule

/* src/mp2d_ctrl.sv */
// Configuration registers and raster position tracking of the max pooling block.
// Depends on mp2d_pkg for the register map and the position flag struct.
module mp2d_ctrl #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_POOL = 8,
	parameter int AW       = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mp2d_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mp2d_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                step,
	output mp2d_pkg::pos_flags_t                flags,
	output logic [AW-1:0]                       col_out
);

	localparam int CW   = $clog2(MAX_COLS + 1);
	localparam int PW   = $clog2(MAX_POOL + 1);
	localparam int WW   = $clog2(MAX_POOL);
	localparam int RW   = mp2d_pkg::ROW_W;
	localparam int CSW  = CW + PW + 1;
	localparam int RSW  = RW + PW + 1;
	localparam int COLS_RST_C = (mp2d_pkg::COLS_RST > MAX_COLS) ? MAX_COLS : mp2d_pkg::COLS_RST;

	logic [RW-1:0] rows_q;
	logic [CW-1:0] cols_q;
	logic [PW-1:0] pr_q;
	logic [PW-1:0] pc_q;

	logic [CW-1:0] col_pos_q;
	logic [CW-1:0] col_base_q;
	logic [RW-1:0] row_pos_q;
	logic [RW-1:0] row_base_q;
	logic [WW-1:0] win_col_q;
	logic [WW-1:0] win_row_q;
	logic [AW-1:0] oc_q;

	logic [RW-1:0] rows_wr;
	logic [CW-1:0] cols_wr;
	logic [PW-1:0] pool_wr;

	logic [CSW-1:0] col_nxt;
	logic [CSW-1:0] col_end;
	logic [CSW-1:0] col_end2;
	logic [RSW-1:0] row_nxt;
	logic [RSW-1:0] row_end;
	logic [RSW-1:0] row_end2;
	logic           col_last;
	logic           row_last;
	logic           wc_last;
	logic           wr_last;

	// Register values clamp on write: zero reads as one, too large as the bound; pool sizes see data[3:0] only.
	always_comb begin
		if (cfg_data == '0) begin
			rows_wr = RW'(1);
		end else if (32'(cfg_data) > 32'(mp2d_pkg::ROW_MAX)) begin
			rows_wr = RW'(mp2d_pkg::ROW_MAX);
		end else begin
			rows_wr = RW'(cfg_data);
		end

		if (cfg_data == '0) begin
			cols_wr = CW'(1);
		end else if (32'(cfg_data) > 32'(MAX_COLS)) begin
			cols_wr = CW'(MAX_COLS);
		end else begin
			cols_wr = CW'(cfg_data);
		end

		if (cfg_data[mp2d_pkg::POOL_REG_W-1:0] == '0) begin
			pool_wr = PW'(1);
		end else if (32'(cfg_data[mp2d_pkg::POOL_REG_W-1:0]) > 32'(MAX_POOL)) begin
			pool_wr = PW'(MAX_POOL);
		end else begin
			pool_wr = PW'(cfg_data[mp2d_pkg::POOL_REG_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RW'(mp2d_pkg::ROWS_RST);
			cols_q <= CW'(COLS_RST_C);
			pr_q   <= PW'(mp2d_pkg::POOL_RST);
			pc_q   <= PW'(mp2d_pkg::POOL_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				mp2d_pkg::REG_INPUT_ROWS: rows_q <= rows_wr;
				mp2d_pkg::REG_INPUT_COLS: cols_q <= cols_wr;
				mp2d_pkg::REG_POOL_ROWS:  pr_q   <= pool_wr;
				mp2d_pkg::REG_POOL_COLS:  pc_q   <= pool_wr;
				default: ;
			endcase
		end
	end

	// A window is complete when its start plus the pool size stays inside the map.
	// It is the frame's last window when one more window would not fit.
	assign col_nxt  = CSW'(col_pos_q) + CSW'(1);
	assign col_end  = CSW'(col_base_q) + CSW'(pc_q);
	assign col_end2 = col_end + CSW'(pc_q);
	assign row_nxt  = RSW'(row_pos_q) + RSW'(1);
	assign row_end  = RSW'(row_base_q) + RSW'(pr_q);
	assign row_end2 = row_end + RSW'(pr_q);

	assign col_last = col_nxt >= CSW'(cols_q);
	assign row_last = row_nxt >= RSW'(rows_q);
	assign wc_last  = PW'(win_col_q) == (pc_q - PW'(1));
	assign wr_last  = PW'(win_row_q) == (pr_q - PW'(1));

	always_comb begin
		flags.in_win      = (col_end <= CSW'(cols_q)) && (row_end <= RSW'(rows_q));
		flags.first_col   = win_col_q == '0;
		flags.last_col    = wc_last;
		flags.use_partial = win_row_q != '0;
		flags.last_row    = wr_last;
		flags.frame_last  = flags.in_win && wc_last && wr_last &&
			(col_end2 > CSW'(cols_q)) && (row_end2 > RSW'(rows_q));
	end

	assign col_out = oc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q  <= '0;
			col_base_q <= '0;
			row_pos_q  <= '0;
			row_base_q <= '0;
			win_col_q  <= '0;
			win_row_q  <= '0;
			oc_q       <= '0;
		end else if (cfg_we) begin
			col_pos_q  <= '0;
			col_base_q <= '0;
			row_pos_q  <= '0;
			row_base_q <= '0;
			win_col_q  <= '0;
			win_row_q  <= '0;
			oc_q       <= '0;
		end else if (step) begin
			if (col_last) begin
				col_pos_q  <= '0;
				col_base_q <= '0;
				win_col_q  <= '0;
				oc_q       <= '0;
				if (row_last) begin
					row_pos_q  <= '0;
					row_base_q <= '0;
					win_row_q  <= '0;
				end else begin
					row_pos_q <= RW'(row_nxt);
					if (wr_last) begin
						win_row_q  <= '0;
						row_base_q <= RW'(row_nxt);
					end else begin
						win_row_q <= win_row_q + WW'(1);
					end
				end
			end else begin
				col_pos_q <= CW'(col_nxt);
				if (wc_last) begin
					win_col_q  <= '0;
					col_base_q <= CW'(col_nxt);
					oc_q       <= oc_q + AW'(1);
				end else begin
					win_col_q <= win_col_q + WW'(1);
				end
			end
		end
	end

endmodule

/* src/max_pool_2d_stream_top.sv */
// Streaming non-overlapping 2-D max pooling over a raster-order feature map.
// A window's last sample enters stage 1; its maximum then enters the output register.
// Throughput: one sample per cycle; sample_stall rises only while a result waits in
// stage 1 behind a full output register that is itself stalled.
// Reset clears positions and the running maximum and loads the register defaults;
// the partial-maximum store is not cleared, since an entry is always written before read.
module max_pool_2d_stream_top #(
	parameter int MAX_COLS    = 1024,
	parameter int MAX_POOL    = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mp2d_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mp2d_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	output logic                                 pooled_valid,
	input  logic                                 pooled_stall,
	output logic signed [SAMPLE_BITS-1:0]        pooled,
	output logic                                 frame_last
);

	localparam int AW = $clog2(MAX_COLS);
	localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

	logic                  cfg_we;
	logic                  accept;
	mp2d_pkg::pos_flags_t  flags_cur;
	logic [AW-1:0]         oc_cur;

	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	mp2d_pkg::pos_flags_t          flags_s1;
	logic [AW-1:0]                 oc_s1;

	logic signed [SAMPLE_BITS-1:0] run_q;
	logic [SAMPLE_BITS-1:0]        rd_data;
	logic signed [SAMPLE_BITS-1:0] partial;
	logic signed [SAMPLE_BITS-1:0] run_new;
	logic signed [SAMPLE_BITS-1:0] win_max;
	logic                          emit_s1;
	logic                          fire_s1;
	logic                          st_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign accept    = sample_valid && !sample_stall;

	mp2d_ctrl #(
		.MAX_COLS (MAX_COLS),
		.MAX_POOL (MAX_POOL),
		.AW       (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (accept),
		.flags     (flags_cur),
		.col_out   (oc_cur)
	);

	// The store entry of the sample's pooled column is read as the sample enters,
	// so the data lines up with stage 1.
	mp2d_store #(
		.DEPTH (MAX_COLS),
		.AW    (AW),
		.DW    (SAMPLE_BITS)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (oc_s1),
		.wdata (win_max),
		.re    (accept),
		.raddr (oc_cur),
		.rdata (rd_data)
	);

	assign partial = $signed(rd_data);

	always_comb begin
		if (flags_s1.first_col || sample_s1 > run_q) begin
			run_new = sample_s1;
		end else begin
			run_new = run_q;
		end
		if (flags_s1.use_partial && partial > run_new) begin
			win_max = partial;
		end else begin
			win_max = run_new;
		end
	end

	assign emit_s1 = valid_s1 && flags_s1.in_win && flags_s1.last_col && flags_s1.last_row;
	assign fire_s1 = valid_s1 && !(emit_s1 && pooled_valid && pooled_stall);
	assign st_we   = fire_s1 && flags_s1.in_win && flags_s1.last_col && !flags_s1.last_row;

	assign sample_stall = valid_s1 && emit_s1 && pooled_valid && pooled_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			flags_s1  <= flags_cur;
			oc_s1     <= oc_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= MOST_NEG;
		end else if (cfg_we) begin
			run_q <= MOST_NEG;
		end else if (fire_s1 && flags_s1.in_win) begin
			run_q <= run_new;
		end
	end

	// Output register: frees stage 1 while the consumer holds the previous result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pooled_valid <= 1'b0;
		end else if (fire_s1 && emit_s1) begin
			pooled_valid <= 1'b1;
		end else if (!pooled_stall) begin
			pooled_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit_s1) begin
			pooled     <= win_max;
			frame_last <= flags_s1.frame_last;
		end
	end

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> valid_s1 && pooled_valid && pooled_stall)
		else $error("input stalled without a blocked result in stage 1");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire_s1 |=> valid_s1 && $stable(sample_s1) && $stable(oc_s1))
		else $error("stage 1 lost or changed a held request");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && emit_s1 |-> !pooled_valid || !pooled_stall)
		else $error("result register overwritten while stalled");

	a_write_xor_emit: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> !emit_s1 && flags_s1.last_col)
		else $error("store written by a request that also emits a result");

endmodule
